// ----- design/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVA_CHECK(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("scheduler assertion failed");
`define SVA_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("scheduler forbidden condition");
`else
`define SVA_CHECK(lbl, prop)
`define SVA_NEVER(lbl, expr)
`endif
`endif

// ----- design/clook_pkg.sv -----
// Types and codes of the C-LOOK request scheduler.
// No dependencies.
package clook_pkg;
	localparam int OP_W = 3;
	localparam int ST_W = 2;
	localparam int TAG_W = 8;
	localparam int SEC_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 3'd0,
		OP_DISPATCH = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_FORMER   = 3'd3,
		OP_LATTER   = 3'd4
	} op_t;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [SEC_W-1:0] key;
		logic [SEC_W-1:0] start;
		logic [TAG_W-1:0] tag;
		logic             wr;
	} entry_t;
endpackage

// ----- design/clook_request_scheduler_top.sv -----
// C-LOOK request scheduler: sorted request queue held in one synchronous RAM.
// Depends on clook_pkg and assert_macros.svh.
// Full, empty and unused ops and add to an empty queue finish straight from idle; add
// reads entries from the tail down, moving each above the insert point up a slot; dispatch
// and remove scan for their entry, then shift the entries behind it down; queries scan for
// the tag, and latter then reads the next entry. One item at a time; busy is high meanwhile.
// done pulses one cycle with the result, never held off. arst_n clears count and position.
`include "assert_macros.svh"
module clook_request_scheduler_top #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [clook_pkg::OP_W-1:0]    operation,
	input  logic [clook_pkg::TAG_W-1:0]   req_tag,
	input  logic [clook_pkg::SEC_W-1:0]   start_sector,
	input  logic [clook_pkg::SEC_W-1:0]   end_sector,
	input  logic                          is_write,
	output logic                          done,
	output logic [clook_pkg::ST_W-1:0]    status,
	output logic [clook_pkg::TAG_W-1:0]   out_tag,
	output logic [clook_pkg::SEC_W-1:0]   out_start,
	output logic [clook_pkg::SEC_W-1:0]   out_end,
	output logic                          out_write
);
	import clook_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_RD, S_ADD_EV, S_ADD_INS, S_SCN_RD, S_SCN_EV,
		S_NBR_RD, S_NBR_EV, S_SHF_RD, S_SHF_EV
	} state_t;

	state_t state_q;
	op_t op_q;
	entry_t new_q, first_q, prev_q, rdata;
	entry_t mem [QUEUE_DEPTH];
	logic [CW-1:0] cnt_q, idx_q;
	logic [SEC_W-1:0] last_q;
	logic done_q;
	logic [ST_W-1:0] status_q;
	entry_t res_q;
	logic accept, we;
	logic add_full;
	logic [AW-1:0] wa;
	entry_t wd, in_ent, sel;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign add_full = accept && (op_t'(operation) == OP_ADD) && (cnt_q == CW'(QUEUE_DEPTH));
	assign in_ent = '{key: end_sector, start: start_sector, tag: req_tag, wr: is_write};
	assign sel = (idx_q == '0) ? rdata : first_q;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = new_q;
		unique case (state_q)
			S_IDLE: begin
				we = accept && (op_t'(operation) == OP_ADD) && (cnt_q == '0);
				wd = in_ent;
			end
			S_ADD_EV: begin
				we = 1'b1;
				wa = AW'(idx_q + 1'b1);
				wd = (rdata.key > new_q.key) ? rdata : new_q;
			end
			S_ADD_INS: we = 1'b1;
			S_SHF_EV: begin
				we = 1'b1;
				wa = AW'(idx_q - 1'b1);
				wd = rdata;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			last_q <= '0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			op_q <= OP_ADD;
			idx_q <= '0;
			new_q <= '0;
			first_q <= '0;
			prev_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= op_t'(operation);
						new_q <= in_ent;
						res_q <= '0;
						status_q <= ST_OK;
						idx_q <= '0;
						unique case (op_t'(operation))
							OP_ADD: begin
								if (cnt_q == CW'(QUEUE_DEPTH)) begin
									status_q <= ST_FULL;
									done_q <= 1'b1;
								end else if (cnt_q == '0) begin
									cnt_q <= cnt_q + 1'b1;
									done_q <= 1'b1;
								end else begin
									idx_q <= cnt_q - 1'b1;
									state_q <= S_ADD_RD;
								end
							end
							OP_DISPATCH, OP_REMOVE, OP_FORMER, OP_LATTER: begin
								if (cnt_q == '0) begin
									status_q <= (op_t'(operation) == OP_DISPATCH)
										? ST_EMPTY : ST_NOTFOUND;
									done_q <= 1'b1;
								end else begin
									state_q <= S_SCN_RD;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_ADD_RD: state_q <= S_ADD_EV;
				S_ADD_EV: begin
					if (rdata.key > new_q.key) begin
						if (idx_q == '0) begin
							state_q <= S_ADD_INS;
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_ADD_RD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ADD_INS: begin
					cnt_q <= cnt_q + 1'b1;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCN_RD: state_q <= S_SCN_EV;
				S_SCN_EV: begin
					if (op_q == OP_DISPATCH) begin
						if (idx_q == '0) begin
							first_q <= rdata;
						end
						if (rdata.key >= last_q) begin
							res_q <= rdata;
							last_q <= rdata.key;
							idx_q <= idx_q + 1'b1;
							state_q <= S_SHF_RD;
						end else if (idx_q == cnt_q - 1'b1) begin
							res_q <= sel;
							last_q <= sel.key;
							idx_q <= CW'(1);
							state_q <= S_SHF_RD;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SCN_RD;
						end
					end else if (rdata.tag == new_q.tag) begin
						priority if (op_q == OP_REMOVE) begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SHF_RD;
						end else if (op_q == OP_FORMER) begin
							if (idx_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								res_q <= prev_q;
							end
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							if (idx_q + 1'b1 >= cnt_q) begin
								status_q <= ST_EMPTY;
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_NBR_RD;
							end
						end
					end else begin
						prev_q <= rdata;
						if (idx_q == cnt_q - 1'b1) begin
							status_q <= ST_NOTFOUND;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SCN_RD;
						end
					end
				end
				S_NBR_RD: state_q <= S_NBR_EV;
				S_NBR_EV: begin
					res_q <= rdata;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SHF_RD: begin
					if (idx_q >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SHF_EV;
					end
				end
				S_SHF_EV: begin
					idx_q <= idx_q + 1'b1;
					state_q <= S_SHF_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign out_tag = res_q.tag;
	assign out_start = res_q.start;
	assign out_end = res_q.key;
	assign out_write = res_q.wr;

	`SVA_CHECK(a_done_idle, done |-> !busy)
	`SVA_NEVER(a_cnt_range, cnt_q > CW'(QUEUE_DEPTH))
	`SVA_CHECK(a_full_reject, add_full |=> (done && status == ST_FULL))
	`SVA_CHECK(a_full_keeps, (done && status == ST_FULL) |-> $stable(cnt_q))
endmodule

// ----- bench/clook_request_scheduler_top_tb.sv -----
// Self-checking bench for the C-LOOK request scheduler: directed table, then random items.
// Results are checked against an in-bench sorted-queue predictor of the scheduler.
// Depends on clook_pkg and clook_request_scheduler_top.
`timescale 1ns / 100ps
module clook_request_scheduler_top_tb;
	import clook_pkg::*;

	localparam int DEPTH = 32;
	localparam int N_RANDOM = 1830;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 4 * DEPTH + 20;
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [TAG_W-1:0] tag;
		logic [SEC_W-1:0] start;
		logic [SEC_W-1:0] end_sec;
		logic             wr;
	} sched_result_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [TAG_W-1:0] tag;
		logic [SEC_W-1:0] s;
		logic [SEC_W-1:0] e;
		logic             w;
		bit               fixed;
		logic [ST_W-1:0]  st;
	} stim_row_t;

	logic clk, arst_n, start, busy, done, is_write, out_write;
	logic [OP_W-1:0] operation;
	logic [TAG_W-1:0] req_tag, out_tag;
	logic [SEC_W-1:0] start_sector, end_sector, out_start, out_end;
	logic [ST_W-1:0] status;

	entry_t sorted_q[DEPTH];
	int q_count;
	logic [SEC_W-1:0] last_pos;
	sched_result_t pending_results[$];
	int errors;
	int cycles;
	bit idle_on;

	clook_request_scheduler_top #(.QUEUE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .req_tag(req_tag), .start_sector(start_sector),
		.end_sector(end_sector), .is_write(is_write), .done(done), .status(status),
		.out_tag(out_tag), .out_start(out_start), .out_end(out_end), .out_write(out_write)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int find_tag(input logic [TAG_W-1:0] tag);
		for (int i = 0; i < q_count; i++)
			if (sorted_q[i].tag == tag) return i;
		return -1;
	endfunction

	function automatic void drop_entry(input int slot);
		for (int i = slot; i + 1 < q_count; i++) sorted_q[i] = sorted_q[i + 1];
		q_count--;
	endfunction

	function automatic sched_result_t entry_result(input int slot);
		sched_result_t r;
		r = '0;
		r.tag = sorted_q[slot].tag;
		r.start = sorted_q[slot].start;
		r.end_sec = sorted_q[slot].key;
		r.wr = sorted_q[slot].wr;
		return r;
	endfunction

	function automatic sched_result_t schedule_step(input logic [OP_W-1:0] op,
			input logic [TAG_W-1:0] tag, input logic [SEC_W-1:0] s,
			input logic [SEC_W-1:0] e, input logic w);
		sched_result_t r;
		int slot;
		r = '0;
		case (op)
			OP_ADD: begin
				if (q_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = 0;
					while (slot < q_count && sorted_q[slot].key <= e) slot++;
					for (int i = q_count; i > slot; i--) sorted_q[i] = sorted_q[i - 1];
					sorted_q[slot] = '{key: e, start: s, tag: tag, wr: w};
					q_count++;
				end
			end
			OP_DISPATCH: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot = 0;
					while (slot < q_count && sorted_q[slot].key < last_pos) slot++;
					if (slot >= q_count) slot = 0;
					r = entry_result(slot);
					last_pos = sorted_q[slot].key;
					drop_entry(slot);
				end
			end
			OP_REMOVE: begin
				slot = find_tag(tag);
				if (slot < 0) r.status = ST_NOTFOUND;
				else drop_entry(slot);
			end
			OP_FORMER, OP_LATTER: begin
				slot = find_tag(tag);
				if (slot < 0) r.status = ST_NOTFOUND;
				else if (op == OP_FORMER && slot == 0) r.status = ST_EMPTY;
				else if (op == OP_LATTER && slot + 1 >= q_count) r.status = ST_EMPTY;
				else r = entry_result(op == OP_FORMER ? slot - 1 : slot + 1);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report($sformatf("status %0d exp %0d", status, exp_r.status));
				if (out_tag !== exp_r.tag)
					report($sformatf("out_tag %0d exp %0d", out_tag, exp_r.tag));
				if (out_start !== exp_r.start)
					report($sformatf("out_start %h exp %h", out_start, exp_r.start));
				if (out_end !== exp_r.end_sec)
					report($sformatf("out_end %h exp %h", out_end, exp_r.end_sec));
				if (out_write !== exp_r.wr)
					report($sformatf("out_write %b exp %b", out_write, exp_r.wr));
			end
		end
	end

	task automatic send_item(input stim_row_t row);
		sched_result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= row.op;
		req_tag <= row.tag;
		start_sector <= row.s;
		end_sector <= row.e;
		is_write <= row.w;
		do @(posedge clk); while (busy);
		r = schedule_step(row.op, row.tag, row.s, row.e, row.w);
		if (row.fixed) begin
			r = '0;
			r.status = row.st;
		end
		pending_results.push_back(r);
	endtask

	function automatic logic [SEC_W-1:0] rand_sector();
		case ($urandom_range(0, 5))
			0: return SEC_MAX;
			1: return '0;
			2, 3: return SEC_W'($urandom_range(0, 40));
			default: return SEC_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic stim_row_t rand_row(input int add_weight);
		stim_row_t row;
		int pick;
		row.fixed = 1'b0;
		row.st = ST_OK;
		pick = $urandom_range(0, 99);
		if (pick < add_weight) row.op = OP_ADD;
		else if (pick < 97) begin
			case ($urandom_range(0, 4))
				0, 1: row.op = OP_DISPATCH;
				2: row.op = OP_REMOVE;
				3: row.op = OP_FORMER;
				default: row.op = OP_LATTER;
			endcase
		end else row.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
		row.tag = ($urandom_range(0, 4) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 23));
		row.s = rand_sector();
		row.e = rand_sector();
		row.w = 1'($urandom_range(0, 1));
		return row;
	endfunction

	initial begin
		stim_row_t table_rows[$];
		int add_weight;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		req_tag = '0;
		start_sector = '0;
		end_sector = '0;
		is_write = 1'b0;
		q_count = 0;
		last_pos = '0;
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		table_rows = '{
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b1, ST_EMPTY},
			'{OP_REMOVE, 8'd5, '0, '0, 1'b0, 1'b1, ST_NOTFOUND},
			'{OP_FORMER, 8'd5, '0, '0, 1'b0, 1'b1, ST_NOTFOUND},
			'{OP_LATTER, 8'd5, '0, '0, 1'b0, 1'b1, ST_NOTFOUND},
			'{OP_RSVD5, 8'hff, SEC_MAX, SEC_MAX, 1'b1, 1'b1, ST_OK},
			'{OP_RSVD6, 8'd0, '0, '0, 1'b0, 1'b1, ST_OK},
			'{OP_RSVD7, 8'haa, SEC_MAX, '0, 1'b1, 1'b1, ST_OK},
			'{OP_ADD, 8'hff, SEC_MAX, SEC_MAX, 1'b1, 1'b1, ST_OK},
			'{OP_ADD, 8'd0, '0, '0, 1'b0, 1'b1, ST_OK},
			'{OP_ADD, 8'd7, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 1'b1, 1'b1, ST_OK},
			'{OP_ADD, 8'd7, 48'd100, 48'haaaa_aaaa_aaaa, 1'b0, 1'b1, ST_OK},
			'{OP_FORMER, 8'd0, '0, '0, 1'b0, 1'b1, ST_EMPTY},
			'{OP_LATTER, 8'hff, '0, '0, 1'b0, 1'b1, ST_EMPTY},
			'{OP_FORMER, 8'hff, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_LATTER, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_LATTER, 8'd7, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_ADD, 8'd9, 48'd3, 48'd1, 1'b1, 1'b1, ST_OK},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_REMOVE, 8'd7, '0, '0, 1'b0, 1'b1, ST_NOTFOUND},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b0, ST_OK},
			'{OP_DISPATCH, 8'd0, '0, '0, 1'b0, 1'b1, ST_EMPTY}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i]) send_item(table_rows[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 150 == 0) add_weight = $urandom_range(0, 1) ? 75 : 25;
			if (n % 100 == 0) idle_on = (n < N_RANDOM - 250) && $urandom_range(0, 2) != 0;
			send_item(rand_row(add_weight));
		end
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+design
design/clook_pkg.sv
design/clook_request_scheduler_top.sv
bench/clook_request_scheduler_top_tb.sv
